>>> rtl/core/assert_macros.svh
// Assertion macros for the port-level checker file.
// No dependencies; included by name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every aclk edge outside reset.
`define TCW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Checked on every aclk edge, reset included.
`define TCW_ASSERT_ANY(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> rtl/core/tcw_pkg.sv
// Shared types and constants of the text console writer.
// No dependencies; imported by every module of the block.
package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;
    localparam int QUEUE_DEPTH = 2;

    localparam int CHAR_W    = 8;
    localparam int ATTR_W    = 8;
    localparam int RA_W      = 11;
    localparam int CELL_W    = 16;
    localparam int POS_W     = 11;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    localparam logic [CHAR_W-1:0] CH_CR       = 8'd13;
    localparam logic [CHAR_W-1:0] CH_LF       = 8'd10;
    localparam logic [CELL_W-1:0] BLANK_CELL  = 16'h0720;
    localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'h07;
    localparam logic              OP_PUT      = 1'b0;
    localparam logic              OP_READ     = 1'b1;

    typedef enum logic [1:0] {
        CMD_PUT,
        CMD_LF,
        CMD_CR,
        CMD_READ
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [CHAR_W-1:0]  char_code;
        logic [ATTR_W-1:0]  attr;
        logic [RA_W-1:0]    read_addr;
    } cmd_t;

    typedef struct packed {
        logic clearing;
    } bk_status_t;

    typedef struct packed {
        logic [CELL_W-1:0] cell_data;
        logic [POS_W-1:0]  cursor_pos;
        logic              scrolled;
    } result_t;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_RUN,
        BK_READ_WAIT,
        BK_COPY,
        BK_BLANK
    } bk_state_t;

endpackage

>>> rtl/core/tcw_fifo.sv
// Short command queue between the front and the back.
// Depends on tcw_pkg for the command type.
module tcw_fifo #(
    parameter int DEPTH = 2
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  tcw_pkg::cmd_t push_entry,
    output logic          full,
    input  logic          pop,
    output tcw_pkg::cmd_t pop_entry,
    output logic          empty
);
    import tcw_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign pop_entry = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> rtl/core/tcw_front.sv
// Front end: input handshake, attribute register, item classification.
// Depends on tcw_pkg; feeds tcw_fifo.
module tcw_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tcw_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                              s_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tcw_pkg::ATTR_W-1:0]        cfg_data,
    input  logic                              q_full,
    input  tcw_pkg::bk_status_t               bk_stat,
    output logic                              push,
    output tcw_pkg::cmd_t                     push_entry
);
    import tcw_pkg::*;

    logic [ATTR_W-1:0] attr_reg;
    logic [CHAR_W-1:0] in_char;
    logic [RA_W-1:0]   in_addr;

    assign in_char   = s_tdata[CHAR_W-1:0];
    assign in_addr   = s_tdata[CHAR_W+RA_W-1:CHAR_W];
    assign cfg_ready = 1'b1;
    // no items during the clearing pass after reset
    assign s_tready  = !q_full && !bk_stat.clearing;
    assign push      = s_tvalid && s_tready;

    always_comb begin
        push_entry.char_code = in_char;
        push_entry.attr      = attr_reg;
        push_entry.read_addr = in_addr;
        if (s_tuser == OP_READ) begin
            push_entry.kind = CMD_READ;
        end else if (in_char == CH_CR) begin
            push_entry.kind = CMD_CR;
        end else if (in_char == CH_LF) begin
            push_entry.kind = CMD_LF;
        end else begin
            push_entry.kind = CMD_PUT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg <= ATTR_RESET;
        end else if (cfg_valid && cfg_ready) begin
            attr_reg <= cfg_data;
        end
    end

endmodule

>>> rtl/core/tcw_back.sv
// Back end: screen memory, cursor, scroll copy, clearing pass, result register.
// Depends on tcw_pkg; pops commands from tcw_fifo.
module tcw_back #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_empty,
    input  tcw_pkg::cmd_t        pop_entry,
    output logic                 pop,
    output tcw_pkg::bk_status_t  bk_stat,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output tcw_pkg::result_t     result
);
    import tcw_pkg::*;

    localparam int CELLS     = COLUMNS * ROWS;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int COL_W     = $clog2(COLUMNS);
    localparam int ROW_W     = $clog2(ROWS);
    localparam int CMP_W     = (ADDR_W + 1 > RA_W) ? ADDR_W + 1 : RA_W;
    localparam int LAST_ROW0 = (ROWS - 1) * COLUMNS;

    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] rd_q;

    bk_state_t         state_reg, state_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ADDR_W-1:0] lin_reg, lin_next;
    logic              cp_pend_reg, cp_pend_next;
    logic [ADDR_W-1:0] cp_dst_reg, cp_dst_next;
    logic              m_valid_reg, m_valid_next;
    result_t           res_reg, res_next;

    logic              wr_en, rd_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [CELL_W-1:0] wr_data;
    logic              load, load_scr, scroll;
    logic [CELL_W-1:0] load_data;
    logic              out_free, last_row, last_col, cnt_last, in_range;
    logic [CMP_W-1:0]  addr_ext;

    assign out_free = !m_valid_reg || m_tready;
    assign last_row = (row_reg == ROW_W'(ROWS - 1));
    assign last_col = (col_reg == COL_W'(COLUMNS - 1));
    assign cnt_last = (cnt_reg == ADDR_W'(CELLS - 1));
    assign addr_ext = CMP_W'(pop_entry.read_addr);
    assign in_range = (addr_ext < CMP_W'(CELLS));

    assign bk_stat.clearing = (state_reg == BK_CLEAR);
    assign m_tvalid = m_valid_reg;
    assign result   = res_reg;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        lin_next     = lin_reg;
        cp_pend_next = cp_pend_reg;
        cp_dst_next  = cp_dst_reg;
        wr_en        = 1'b0;
        wr_addr      = cnt_reg;
        wr_data      = BLANK_CELL;
        rd_en        = 1'b0;
        rd_addr      = cnt_reg;
        pop          = 1'b0;
        load         = 1'b0;
        load_scr     = 1'b0;
        load_data    = '0;
        scroll       = 1'b0;

        case (state_reg)
            BK_CLEAR: begin
                wr_en = 1'b1;
                if (cnt_last) begin
                    state_next = BK_RUN;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            BK_RUN: begin
                if (!q_empty && out_free) begin
                    pop = 1'b1;
                    case (pop_entry.kind)
                        CMD_READ: begin
                            if (in_range) begin
                                rd_en      = 1'b1;
                                rd_addr    = addr_ext[ADDR_W-1:0];
                                state_next = BK_READ_WAIT;
                            end else begin
                                load = 1'b1;
                            end
                        end
                        CMD_CR: begin
                            load = 1'b1;
                        end
                        CMD_LF: begin
                            if (last_row) begin
                                scroll = 1'b1;
                            end else begin
                                row_next = row_reg + 1'b1;
                                col_next = '0;
                                lin_next = lin_reg + ADDR_W'(COLUMNS) - ADDR_W'(col_reg);
                                load     = 1'b1;
                            end
                        end
                        CMD_PUT: begin
                            wr_en   = 1'b1;
                            wr_addr = lin_reg;
                            wr_data = {pop_entry.attr, pop_entry.char_code};
                            if (last_col && last_row) begin
                                scroll = 1'b1;
                            end else begin
                                if (last_col) begin
                                    row_next = row_reg + 1'b1;
                                    col_next = '0;
                                end else begin
                                    col_next = col_reg + 1'b1;
                                end
                                lin_next = lin_reg + 1'b1;
                                load     = 1'b1;
                            end
                        end
                        default: begin
                            load = 1'b1;
                        end
                    endcase
                    if (scroll) begin
                        row_next   = ROW_W'(ROWS - 1);
                        col_next   = '0;
                        lin_next   = ADDR_W'(LAST_ROW0);
                        cnt_next   = ADDR_W'(COLUMNS);
                        state_next = BK_COPY;
                    end
                end
            end
            BK_READ_WAIT: begin
                load       = 1'b1;
                load_data  = rd_q;
                state_next = BK_RUN;
            end
            BK_COPY: begin
                // read row r+1 while writing the word of the last read (rd_q)
                rd_en        = 1'b1;
                rd_addr      = cnt_reg;
                cp_pend_next = 1'b1;
                cp_dst_next  = cnt_reg - ADDR_W'(COLUMNS);
                if (cp_pend_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = cp_dst_reg;
                    wr_data = rd_q;
                end
                if (cnt_last) begin
                    state_next = BK_BLANK;
                    cnt_next   = ADDR_W'(LAST_ROW0);
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            BK_BLANK: begin
                wr_en = 1'b1;
                if (cp_pend_reg) begin
                    wr_addr      = cp_dst_reg;
                    wr_data      = rd_q;
                    cp_pend_next = 1'b0;
                end else if (cnt_last) begin
                    load       = 1'b1;
                    load_scr   = 1'b1;
                    state_next = BK_RUN;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default: begin
                state_next = BK_CLEAR;
            end
        endcase

        m_valid_next = m_valid_reg;
        res_next     = res_reg;
        if (load) begin
            m_valid_next        = 1'b1;
            res_next.cell_data  = load_data;
            res_next.cursor_pos = POS_W'(lin_next);
            res_next.scrolled   = load_scr;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_CLEAR;
            cnt_reg     <= '0;
            row_reg     <= '0;
            col_reg     <= '0;
            lin_reg     <= '0;
            cp_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            lin_reg     <= lin_next;
            cp_pend_reg <= cp_pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cp_dst_reg <= cp_dst_next;
        res_reg    <= res_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_q <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/core/text_console_writer_core.sv
// Top level of the text console writer: front end, command queue, back end.
// Depends on tcw_pkg, tcw_front, tcw_fifo and tcw_back.
//
//  channel   dir  handshake            payload
//  s_        in   s_tvalid / s_tready  s_tdata: char_code, read_addr; s_tuser: op
//  m_        out  m_tvalid / m_tready  m_tdata: cell_data, cursor_pos, scrolled
//  cfg_      in   cfg_valid/cfg_ready  cfg_data: text_attribute
//
// Put, carriage return and line feed items retire in the back end's run state,
// an in-range read in the read-wait state (one registered screen memory read port).
// A scroll holds the back end while it copies one cell per cycle through the single
// memory write port, then blanks the bottom row.
// After reset a clearing pass writes the blank cell to all COLUMNS*ROWS
// entries, one per cycle, with s_tready low; cfg writes are taken throughout.
// The queue keeps taking items while the back end or the m_ side stalls, until full.
module text_console_writer_core #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input items
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tcw_pkg::S_TDATA_W-1:0] s_tdata,   // [7:0] char_code, [18:8] read_addr
    input  logic                          s_tuser,   // [0] op
    // results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tcw_pkg::M_TDATA_W-1:0] m_tdata,   // [15:0] cell_data,
                                                     // [26:16] cursor_pos, [27] scrolled
    // attribute register write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tcw_pkg::ATTR_W-1:0]    cfg_data
);
    import tcw_pkg::*;

    localparam int RES_W = CELL_W + POS_W + 1;

    cmd_t       push_entry, pop_entry;
    logic       push, pop, q_full, q_empty;
    bk_status_t bk_stat;
    result_t    result;

    tcw_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .q_full     (q_full),
        .bk_stat    (bk_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    tcw_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .empty      (q_empty)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .pop_entry (pop_entry),
        .pop       (pop),
        .bk_stat   (bk_stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .result    (result)
    );

    // cell_data lowest, then cursor_pos, then scrolled, zero pad to 32 bits
    assign m_tdata = {{(M_TDATA_W - RES_W){1'b0}}, result.scrolled,
                      result.cursor_pos, result.cell_data};

endmodule

>>> rtl/core/tcw_checker.sv
// Port-level assertions for text_console_writer_core, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module tcw_assertions (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    `TCW_ASSERT(a_m_valid_hold, m_tvalid && !m_tready |=> m_tvalid, "m_tvalid dropped in stall")
    `TCW_ASSERT(a_m_data_hold, m_tvalid && !m_tready |=> $stable(m_tdata), "m_tdata moved")
    `TCW_ASSERT(a_scroll_cell, m_tvalid && m_tdata[27] |-> m_tdata[15:0] == '0, "cell on scroll")
    `TCW_ASSERT_ANY(a_reset_quiet, !aresetn |=> !m_tvalid && !s_tready, "busy after reset")

endmodule

bind text_console_writer_core tcw_assertions u_tcw_assertions (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> test/tcw_checker.sv
// Result checker for text_console_writer_core: keeps a shadow screen, cursor and
// attribute, predicts one result per accepted item and compares it on the m_ side.
// Depends on tcw_pkg.
module tcw_checker #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [tcw_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [tcw_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [tcw_pkg::ATTR_W-1:0]    cfg_data,
    output int                            mismatches,
    output int                            outstanding,
    output int                            scroll_total,
    output int                            read_total
);
    import tcw_pkg::*;

    localparam int CELLS        = COLUMNS * ROWS;
    localparam int REPORT_LIMIT = 10;

    logic [CELL_W-1:0] screen_shadow [CELLS];
    int unsigned       cur_row;
    int unsigned       cur_col;
    logic [ATTR_W-1:0] attr_shadow;
    result_t           pending_results [$];

    // Move to column 0 of the next row; scroll when leaving the bottom row.
    function automatic logic advance_row();
        cur_col = 0;
        if (cur_row + 1 >= ROWS) begin
            for (int i = 0; i < CELLS - COLUMNS; i++)
                screen_shadow[i] = screen_shadow[i + COLUMNS];
            for (int i = CELLS - COLUMNS; i < CELLS; i++)
                screen_shadow[i] = BLANK_CELL;
            return 1'b1;
        end
        cur_row++;
        return 1'b0;
    endfunction

    function automatic result_t console_step(input logic op, input logic [CHAR_W-1:0] ch,
                                             input logic [RA_W-1:0] addr);
        result_t r;
        r = '0;
        if (op == OP_READ) begin
            if (addr < CELLS)
                r.cell_data = screen_shadow[addr];
        end else if (ch == CH_LF) begin
            r.scrolled = advance_row();
        end else if (ch != CH_CR) begin
            screen_shadow[cur_row * COLUMNS + cur_col] = {attr_shadow, ch};
            cur_col++;
            if (cur_col >= COLUMNS)
                r.scrolled = advance_row();
        end
        r.cursor_pos = POS_W'(cur_row * COLUMNS + cur_col);
        return r;
    endfunction

    task automatic note_failure(input string what);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t ERROR %s", $time, what);
    endtask

    always @(posedge aclk) begin
        result_t want;
        result_t got;
        if (!aresetn) begin
            foreach (screen_shadow[i])
                screen_shadow[i] = BLANK_CELL;
            cur_row      = 0;
            cur_col      = 0;
            attr_shadow  = ATTR_RESET;
            mismatches   = 0;
            scroll_total = 0;
            read_total   = 0;
            pending_results.delete();
            outstanding <= 0;
        end else begin
            if (cfg_valid && cfg_ready)
                attr_shadow = cfg_data;
            if (s_tvalid && s_tready) begin
                want = console_step(s_tuser, s_tdata[CHAR_W-1:0], s_tdata[CHAR_W +: RA_W]);
                pending_results.push_back(want);
                if (s_tuser == OP_READ)
                    read_total++;
                if (want.scrolled)
                    scroll_total++;
            end
            if (m_tvalid && m_tready) begin
                got.cell_data  = m_tdata[CELL_W-1:0];
                got.cursor_pos = m_tdata[CELL_W +: POS_W];
                got.scrolled   = m_tdata[CELL_W + POS_W];
                if (pending_results.size() == 0) begin
                    note_failure($sformatf("unexpected result %h", m_tdata));
                end else begin
                    want = pending_results.pop_front();
                    if (got.cell_data !== want.cell_data || got.cursor_pos !== want.cursor_pos
                        || got.scrolled !== want.scrolled)
                        note_failure($sformatf(
                            "cell_data exp %h got %h, cursor_pos exp %0d got %0d, scrolled exp %0b got %0b",
                            want.cell_data, got.cell_data, want.cursor_pos, got.cursor_pos,
                            want.scrolled, got.scrolled));
                end
            end
            outstanding <= pending_results.size();
        end
    end

endmodule

>>> test/tb_top.sv
// Testbench top for text_console_writer_core: clock, reset, item and attribute
// stimulus, result back-pressure and verdict. Depends on tcw_pkg and tcw_checker.
module tb_top;
    import tcw_pkg::*;

    localparam int COLUMNS        = DEF_COLUMNS;
    localparam int ROWS           = DEF_ROWS;
    localparam int CELLS          = COLUMNS * ROWS;
    localparam int RANDOM_ITEMS   = 1880;
    localparam int PHASES         = 8;
    // a scroll or the clearing pass keeps every channel quiet while it rewrites memory
    localparam int WATCHDOG_LIMIT = 20 * CELLS;
    localparam int DRAIN_CYCLES   = 8;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tready  = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [ATTR_W-1:0]    cfg_data  = '0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic                 cfg_ready;
    logic [M_TDATA_W-1:0] m_tdata;

    int mismatches;
    int outstanding;
    int scroll_total;
    int read_total;

    bit idle_on;         // random gaps on both sides when set
    int items_sent;
    int directed_items;
    int attr_writes;
    int stall_left;
    int idle_cycles;

    always #2 aclk = ~aclk;

    text_console_writer_core #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    tcw_checker #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .scroll_total(scroll_total),
        .read_total  (read_total)
    );

    // Result side back-pressure: with idle_on set, m_tready drops in random bursts.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= (stall_left == 1);
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(1, 13);
        end else begin
            m_tready   <= 1'b1;
        end
    end

    // Watchdog: ends the run once no channel has moved anything for too long.
    initial begin : watchdog
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t watchdog: no progress for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, outstanding);
        $display("Test completed with failures");
        $finish;
    end

    // One item on the s_ channel; with idle_on set, an optional random gap first.
    task automatic send_item(input logic op, input logic [CHAR_W-1:0] ch,
                             input logic [RA_W-1:0] addr);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_TDATA_W - CHAR_W - RA_W){1'b0}}, addr, ch};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // Stop sending and hold until every predicted result has come back.
    // The first edge lets the checker count the item accepted at this edge.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
    endtask

    task automatic write_attr(input logic [ATTR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        attr_writes++;
    endtask

    // Random mix: mostly text, line feeds often enough to scroll many times,
    // reads biased to the bottom row where new text and blanking land.
    task automatic send_random_item();
        int              pick;
        logic [CHAR_W-1:0] ch;
        logic [RA_W-1:0]   addr;
        pick = $urandom_range(0, 99);
        ch   = CHAR_W'($urandom_range(0, 2**CHAR_W - 1));
        addr = RA_W'($urandom_range(0, 2**RA_W - 1));
        if (pick < 55)
            send_item(OP_PUT, ch, addr);
        else if (pick < 63)
            send_item(OP_PUT, CH_LF, addr);
        else if (pick < 66)
            send_item(OP_PUT, CH_CR, addr);
        else if (pick < 80)
            send_item(OP_READ, ch, RA_W'($urandom_range(CELLS - COLUMNS, CELLS - 1)));
        else if (pick < 95)
            send_item(OP_READ, ch, RA_W'($urandom_range(0, CELLS - 1)));
        else
            send_item(OP_READ, ch, RA_W'($urandom_range(CELLS, 2**RA_W - 1)));
    endtask

    function automatic logic [ATTR_W-1:0] phase_attr(input int p);
        case (p)
            0:       return 8'h0F;
            1:       return 8'hF0;
            2:       return 8'hFF;
            3:       return 8'h00;
            default: return ATTR_W'($urandom_range(0, 2**ATTR_W - 1));
        endcase
    endfunction

    initial begin : stimulus
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        idle_on = 1'b1;

        // Directed: reads of fresh blanks and out of range, field extremes, CR, LF.
        // The block starts with its reset attribute (grey on black).
        send_item(OP_READ, 8'h00, 11'd0);
        send_item(OP_READ, 8'hFF, RA_W'(CELLS - 1));
        send_item(OP_READ, 8'h00, RA_W'(CELLS));      // first index past the screen
        send_item(OP_READ, 8'h00, 11'h7FF);
        send_item(OP_PUT, 8'h41, 11'h7FF);
        send_item(OP_PUT, 8'h00, 11'd0);
        send_item(OP_PUT, 8'hFF, 11'h7FF);
        send_item(OP_PUT, CH_CR, 11'd0);              // carriage return leaves the cursor
        send_item(OP_READ, 8'h00, 11'd0);
        send_item(OP_READ, 8'h00, 11'd2);
        send_item(OP_PUT, CH_LF, 11'd0);
        send_item(OP_PUT, 8'h20, 11'd0);
        send_item(OP_READ, 8'h00, RA_W'(COLUMNS));
        drain_results();
        write_attr(8'hFF);
        send_item(OP_PUT, 8'h7E, 11'd0);
        send_item(OP_READ, 8'h00, RA_W'(COLUMNS + 1));
        send_item(OP_PUT, CH_CR, 11'h7FF);
        send_item(OP_PUT, CH_LF, 11'h7FF);
        drain_results();
        write_attr(8'h00);
        send_item(OP_PUT, 8'h0E, 11'd0);
        send_item(OP_PUT, 8'h0F, 11'd0);
        send_item(OP_READ, 8'hFF, RA_W'(2 * COLUMNS));
        send_item(OP_READ, 8'hFF, RA_W'(2 * COLUMNS + 1));
        directed_items = items_sent;

        // Random phases, each under its own attribute. Some phases run without
        // gaps, and the last two never idle.
        for (int p = 0; p < PHASES; p++) begin
            idle_on = (p < PHASES - 2) && (p % 3 != 1);
            drain_results();
            write_attr(phase_attr(p));
            repeat (RANDOM_ITEMS / PHASES) send_random_item();
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d items (%0d directed, %0d reads) over %0d attribute settings,",
                 items_sent, directed_items, read_total, attr_writes + 1);
        $display("with %0d scrolls, line wraps, carriage returns and out-of-range reads.",
                 scroll_total);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
